@@ hdl/lcrb_pkg.sv @@
`default_nettype none

package lcrb_pkg;

    // Width of the sector number that the divider chain works on. Every
    // address below the CHS limit fits in it.
    localparam int LbaW = 24;
    // Divisor and remainder width; the largest divisor is 256 heads.
    localparam int DivW = 9;
    // Division steps per divider and cells in the whole chain.
    localparam int StepsPerDiv = LbaW;
    localparam int NumCells = 2 * StepsPerDiv;

    // 1024 cylinders * 256 heads * 63 sectors.
    localparam logic [63:0] ChsLimit = 64'd16515072;

    localparam logic [7:0] ReadFunc = 8'h02;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CHS_LIMIT = 2'd1,
        ST_CYL_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_SECTORS_PER_TRACK = 3'd0,
        REG_HEAD_COUNT        = 3'd1,
        REG_CYLINDER_COUNT    = 3'd2,
        REG_DRIVE_NUMBER      = 3'd3,
        REG_BUFFER_SEGMENT    = 3'd4
    } cfg_reg_t;

    // Fields that ride along the chain untouched by the division cells.
    typedef struct packed {
        logic       lim;
        logic [7:0] count;
        logic [5:0] sector;
    } side_t;

    // What one cell hands to its neighbor: partial remainder, the word that
    // shifts dividend bits out at the top and quotient bits in at the bottom.
    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [LbaW-1:0] work;
        side_t           side;
    } cell_data_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  cylinder;
        logic [7:0]  head;
        logic [5:0]  sector_in_track;
        logic [15:0] ax_word;
        logic [15:0] cx_word;
        logic [15:0] dx_word;
        logic [15:0] es_word;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/lcrb_div_cell.sv @@
`default_nettype none

// One restoring division step: brings down the next dividend bit, subtracts
// the divisor when it fits and shifts the quotient bit in.
module lcrb_div_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      valid_in,
    input  wire lcrb_pkg::cell_data_t      data_in,
    input  wire logic [lcrb_pkg::DivW-1:0] divisor,
    output logic                           valid_out,
    output lcrb_pkg::cell_data_t           data_out
);

    logic                 valid_reg;
    lcrb_pkg::cell_data_t data_reg;
    lcrb_pkg::cell_data_t data_next;
    logic [lcrb_pkg::DivW:0] trial;
    logic [lcrb_pkg::DivW:0] diff;
    logic                    fits;

    always_comb
    begin
        trial = {data_in.rem, data_in.work[lcrb_pkg::LbaW-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
        data_next      = data_in;
        data_next.rem  = fits ? diff[lcrb_pkg::DivW-1:0] : trial[lcrb_pkg::DivW-1:0];
        data_next.work = {data_in.work[lcrb_pkg::LbaW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

@@ hdl/lcrb_pack.sv @@
`default_nettype none

// Status from the limit flag and a range check on the cylinder, and packing
// of the register image into the output register.
module lcrb_pack (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  valid_in,
    input  wire lcrb_pkg::cell_data_t  data_in,
    input  wire logic [10:0]           cyl_limit,
    input  wire logic [7:0]            drive,
    input  wire logic [15:0]           segment,
    output logic                       valid_out,
    output lcrb_pkg::result_t          result
);

    logic              valid_reg;
    lcrb_pkg::result_t result_reg;
    lcrb_pkg::result_t result_next;
    logic [9:0]        cyl;
    logic [7:0]        hd;
    logic [5:0]        sec;

    always_comb
    begin
        cyl = data_in.work[9:0];
        hd  = data_in.rem[7:0];
        sec = data_in.side.sector;
        result_next = '0;
        if (data_in.side.lim)
        begin
            result_next.status = lcrb_pkg::ST_CHS_LIMIT;
        end
        else if (data_in.work >= {{(lcrb_pkg::LbaW-11){1'b0}}, cyl_limit})
        begin
            result_next.status = lcrb_pkg::ST_CYL_RANGE;
        end
        else
        begin
            result_next.status          = lcrb_pkg::ST_OK;
            result_next.cylinder        = cyl;
            result_next.head            = hd;
            result_next.sector_in_track = sec;
            result_next.ax_word         = {lcrb_pkg::ReadFunc, data_in.side.count};
            result_next.cx_word         = {cyl[7:0], cyl[9:8], sec};
            result_next.dx_word         = {hd, drive};
            result_next.es_word         = segment;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign valid_out = valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

@@ hdl/lba_to_chs_request_builder.sv @@
`default_nettype none

// LBA to CHS request builder. Each request carries a logical sector number
// and a sector count; the block divides the sector number by the configured
// sectors per track and then by the head count, and returns cylinder, head,
// one-based sector and the INT13 read register image (AX, CX, DX, ES).
// Addresses at or beyond 1024*256*63 sectors get status 1, and a cylinder
// at or above the configured cylinder count gets status 2; an error result
// carries zeros in every other field. The work is done by a chain of 48
// division cells, 24 for each of the two divisions, one quotient bit per
// cell, followed by an output register. The first cell loads a request at
// the edge that accepts it, and a new request is taken every cycle while
// the output is not stalled. The whole chain stalls only while the output
// register holds a result that the consumer has not taken. A geometry of
// zero sectors per track or zero heads is taken as 63 and 255, head counts
// above 256 as 256 and cylinder counts above 1024 as 1024. Configuration
// writes are always accepted; they must only be made while no request is
// in flight.
module lba_to_chs_request_builder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // logical_sector[63:0], sector_count[71:64]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // status[1:0], cylinder[11:2], head[19:12],
                                        // sector_in_track[25:20], ax_word[41:26],
                                        // cx_word[57:42], dx_word[73:58],
                                        // es_word[89:74], zero fill [95:90]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Geometry and register image configuration.
    logic [5:0]  sectors_per_track_reg;
    logic [8:0]  head_count_reg;
    logic [10:0] cylinder_count_reg;
    logic [7:0]  drive_number_reg;
    logic [15:0] buffer_segment_reg;

    // Effective geometry after the zero and oversize substitutions.
    logic [5:0]  spt_eff;
    logic [8:0]  heads_eff;
    logic [10:0] cyls_eff;

    logic en;

    logic                 chain_valid [0:lcrb_pkg::NumCells];
    lcrb_pkg::cell_data_t chain_data  [0:lcrb_pkg::NumCells];
    lcrb_pkg::cell_data_t entry_data;
    lcrb_pkg::cell_data_t mid_data;

    lcrb_pkg::result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sectors_per_track_reg <= 6'd63;
            head_count_reg        <= 9'd255;
            cylinder_count_reg    <= 11'd1024;
            drive_number_reg      <= 8'd128;
            buffer_segment_reg    <= 16'd12288;
        end
        else if (cfg_valid)
        begin
            case (lcrb_pkg::cfg_reg_t'(cfg_index))
                lcrb_pkg::REG_SECTORS_PER_TRACK: sectors_per_track_reg <= cfg_data[5:0];
                lcrb_pkg::REG_HEAD_COUNT:        head_count_reg        <= cfg_data[8:0];
                lcrb_pkg::REG_CYLINDER_COUNT:    cylinder_count_reg    <= cfg_data[10:0];
                lcrb_pkg::REG_DRIVE_NUMBER:      drive_number_reg      <= cfg_data[7:0];
                lcrb_pkg::REG_BUFFER_SEGMENT:    buffer_segment_reg    <= cfg_data;
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        spt_eff = (sectors_per_track_reg == 6'd0) ? 6'd63 : sectors_per_track_reg;
        if (head_count_reg == 9'd0)
        begin
            heads_eff = 9'd255;
        end
        else if (head_count_reg > 9'd256)
        begin
            heads_eff = 9'd256;
        end
        else
        begin
            heads_eff = head_count_reg;
        end
        cyls_eff = (cylinder_count_reg > 11'd1024) ? 11'd1024 : cylinder_count_reg;
    end

    // The whole chain moves together unless a finished result is stuck in
    // the output register.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Entry: the limit check is done once here; only the low bits of an
    // address that passes it matter to the dividers.
    always_comb
    begin
        entry_data             = '0;
        entry_data.work        = s_tdata[lcrb_pkg::LbaW-1:0];
        entry_data.side.lim    = (s_tdata[63:0] >= lcrb_pkg::ChsLimit);
        entry_data.side.count  = s_tdata[71:64];
    end

    assign chain_valid[0] = s_tvalid;
    assign chain_data[0]  = entry_data;

    // Between the two dividers the remainder becomes the one-based sector
    // and the track number becomes the next dividend.
    always_comb
    begin
        mid_data             = chain_data[lcrb_pkg::StepsPerDiv];
        mid_data.rem         = '0;
        mid_data.side.sector = chain_data[lcrb_pkg::StepsPerDiv].rem[5:0] + 6'd1;
    end

    for (genvar k = 0; k < lcrb_pkg::NumCells; k++)
    begin : g_cell
        lcrb_pkg::cell_data_t      cell_in;
        logic [lcrb_pkg::DivW-1:0] cell_div;

        if (k < lcrb_pkg::StepsPerDiv)
        begin : g_track
            assign cell_in  = chain_data[k];
            assign cell_div = {3'b000, spt_eff};
        end
        else if (k == lcrb_pkg::StepsPerDiv)
        begin : g_mid
            assign cell_in  = mid_data;
            assign cell_div = heads_eff;
        end
        else
        begin : g_head
            assign cell_in  = chain_data[k];
            assign cell_div = heads_eff;
        end

        lcrb_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (chain_valid[k]),
            .data_in   (cell_in),
            .divisor   (cell_div),
            .valid_out (chain_valid[k+1]),
            .data_out  (chain_data[k+1])
        );
    end

    lcrb_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (chain_valid[lcrb_pkg::NumCells]),
        .data_in   (chain_data[lcrb_pkg::NumCells]),
        .cyl_limit (cyls_eff),
        .drive     (drive_number_reg),
        .segment   (buffer_segment_reg),
        .valid_out (m_tvalid),
        .result    (result)
    );

    assign m_tdata = {6'b000000, result.es_word, result.dx_word, result.cx_word,
                      result.ax_word, result.sector_in_track, result.head,
                      result.cylinder, result.status};

    // A rejected request carries nothing but its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.status != lcrb_pkg::ST_OK) |->
            (result.cylinder == 10'd0) && (result.head == 8'd0) &&
            (result.sector_in_track == 6'd0) && (result.ax_word == 16'd0) &&
            (result.cx_word == 16'd0) && (result.dx_word == 16'd0) &&
            (result.es_word == 16'd0))
        else $error("error result carries nonzero fields");

    // Sector numbers count from one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.status == lcrb_pkg::ST_OK) |-> (result.sector_in_track != 6'd0))
        else $error("sector zero on a good result");

    // The packed CX and DX words agree with the separate fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.status == lcrb_pkg::ST_OK) |->
            (result.cx_word == {result.cylinder[7:0], result.cylinder[9:8],
                                result.sector_in_track}) &&
            (result.dx_word[15:8] == result.head))
        else $error("register image does not match CHS fields");

    // A good result never names a cylinder at or above the configured count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (result.status == lcrb_pkg::ST_OK) |->
            ({1'b0, result.cylinder} < cyls_eff))
        else $error("cylinder out of range reported as good");

    // When the output is stalled the chain must not advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(chain_valid[lcrb_pkg::NumCells]))
        else $error("chain moved while output stalled");

endmodule

`default_nettype wire
